// ----- rtl/lez_pkg.sv -----
// Shared types, widths and sequencer codes for the Lorenz Euler integrator.
package lez_pkg;

   // Fixed-point formats
   localparam int COORD_W = 32;   // signed Q8.24 coordinate
   localparam int COEF_W  = 31;   // unsigned Q7.24 coefficient
   localparam int DT_W    = 24;   // unsigned Q0.24 time step
   localparam int FRAC_W  = 24;

   // Shared multiplier geometry: the A operand is split into two chunks
   localparam int OPA_W   = 44;
   localparam int OPB_W   = 34;
   localparam int CHUNK_W = 22;
   localparam int PART_W  = CHUNK_W + 1;
   localparam int PROD_W  = PART_W + OPB_W;
   localparam int ACC_W   = OPA_W + OPB_W;
   localparam int SUM_W   = OPA_W + 1;

   // Product schedule, one code per product of the Euler step
   localparam int NUM_OPS = 7;
   localparam int OP_W    = 3;
   localparam logic [OP_W-1:0] OP_SG_DX = 3'd0;  // sigma*(y-x)
   localparam logic [OP_W-1:0] OP_EX    = 3'd1;  // (..)*dt
   localparam logic [OP_W-1:0] OP_X_RZ  = 3'd2;  // x*(rho-z)
   localparam logic [OP_W-1:0] OP_EY    = 3'd3;  // (..-y)*dt
   localparam logic [OP_W-1:0] OP_XY    = 3'd4;  // x*y
   localparam logic [OP_W-1:0] OP_BZ    = 3'd5;  // beta*z
   localparam logic [OP_W-1:0] OP_EZ    = 3'd6;  // (..-..)*dt
   localparam logic [OP_W-1:0] OP_LAST  = OP_EZ;

   // Phases of one product
   localparam int PH_W = 2;
   localparam logic [PH_W-1:0] PH_LO  = 2'd0;  // issue low chunk
   localparam logic [PH_W-1:0] PH_HI  = 2'd1;  // issue high chunk, hold low product
   localparam logic [PH_W-1:0] PH_ACC = 2'd2;  // combine and store

   // Sequencer to datapath control
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [PH_W-1:0] phase;
      logic            run;
      logic            fin_fire;
      logic            fin_load;
   } ctrl_type;

   // Clip a wide sum to a coordinate; top bit of the result is the clip flag
   function automatic logic [COORD_W:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
      if (fits) begin
         sat_coord = {1'b0, v[COORD_W-1:0]};
      end else if (v[SUM_W-1]) begin
         sat_coord = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_coord = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

// ----- rtl/lorenz_euler_step.sv -----
// Step item: seven products, each as low chunk, high chunk and combine phases on the one
// shared chunk multiplier, then clip/write; no new item is taken until the step finishes.
// Load item: result loaded through the finish state; the point is replaced at accept.
// A new item is accepted while the previous result still waits in the output register.
// Synchronous active-high reset: coefficients to 10, 20, 8/3, dt 0.01, point (1,0,0),
// output register empty.
module lorenz_euler_step
   import lez_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration write port
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [COEF_W-1:0]         csr_wdata,
   // input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic                      rsp_saturated
);

   localparam logic [1:0] CSR_SIGMA = 2'd0;
   localparam logic [1:0] CSR_RHO   = 2'd1;
   localparam logic [1:0] CSR_BETA  = 2'd2;
   localparam logic [1:0] CSR_DT    = 2'd3;

   localparam logic [COEF_W-1:0]  SIGMA_RST = 31'd167772160;
   localparam logic [COEF_W-1:0]  RHO_RST   = 31'd335544320;
   localparam logic [COEF_W-1:0]  BETA_RST  = 31'd44739243;
   localparam logic [DT_W-1:0]    DT_RST    = 24'd167772;
   localparam logic [COORD_W-1:0] X_RST     = 32'd16777216;

   ctrl_type ctrl;
   logic     out_free;

   logic [COEF_W-1:0] sigma_ff, rho_ff, beta_ff;
   logic [DT_W-1:0]   dt_ff;

   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [OPA_W-1:0]   res_ff [NUM_OPS];
   logic signed [ACC_W-1:0]   acc_ff;

   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [PART_W-1:0] part;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  total;

   logic [COORD_W:0] nx, ny, nz;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                      rsp_sat_ff;

   lez_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .out_free   (out_free),
      .req_ready  (req_ready),
      .ctrl       (ctrl)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RST;
         rho_ff   <= RHO_RST;
         beta_ff  <= BETA_RST;
         dt_ff    <= DT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIGMA: sigma_ff <= csr_wdata;
            CSR_RHO:   rho_ff   <= csr_wdata;
            CSR_BETA:  beta_ff  <= csr_wdata;
            CSR_DT:    dt_ff    <= csr_wdata[DT_W-1:0];
         endcase
      end
   end

   // Select the operands of the current product
   always_comb begin
      unique case (ctrl.op)
         OP_SG_DX: begin
            opa = OPA_W'(y_ff) - OPA_W'(x_ff);
            opb = $signed({{(OPB_W-COEF_W){1'b0}}, sigma_ff});
         end
         OP_EX: begin
            opa = res_ff[OP_SG_DX];
            opb = $signed({{(OPB_W-DT_W){1'b0}}, dt_ff});
         end
         OP_X_RZ: begin
            opa = $signed({{(OPA_W-COEF_W){1'b0}}, rho_ff}) - OPA_W'(z_ff);
            opb = OPB_W'(x_ff);
         end
         OP_EY: begin
            opa = res_ff[OP_X_RZ] - OPA_W'(y_ff);
            opb = $signed({{(OPB_W-DT_W){1'b0}}, dt_ff});
         end
         OP_XY: begin
            opa = OPA_W'(y_ff);
            opb = OPB_W'(x_ff);
         end
         OP_BZ: begin
            opa = OPA_W'(z_ff);
            opb = $signed({{(OPB_W-COEF_W){1'b0}}, beta_ff});
         end
         OP_EZ: begin
            opa = res_ff[OP_XY] - res_ff[OP_BZ];
            opb = $signed({{(OPB_W-DT_W){1'b0}}, dt_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // Low chunk is unsigned, high chunk carries the sign
   assign part = (ctrl.phase == PH_LO) ? $signed({1'b0, opa[CHUNK_W-1:0]})
                                       : $signed({opa[OPA_W-1], opa[OPA_W-1:CHUNK_W]});

   lez_mul u_mul (
      .clock (clock),
      .mul_a (part),
      .mul_b (opb),
      .prod  (prod)
   );

   // Combine the two partial products; the shift right floors to Q20.24
   assign total = acc_ff + (ACC_W'(prod) <<< CHUNK_W);

   always_ff @(posedge clock) begin
      if (ctrl.run && (ctrl.phase == PH_HI)) begin
         acc_ff <= ACC_W'(prod);
      end
      if (ctrl.run && (ctrl.phase == PH_ACC)) begin
         res_ff[ctrl.op] <= total[FRAC_W +: OPA_W];
      end
   end

   // New coordinates, clipped to 32 bits
   assign nx = sat_coord(SUM_W'(x_ff) + SUM_W'(res_ff[OP_EX]));
   assign ny = sat_coord(SUM_W'(y_ff) + SUM_W'(res_ff[OP_EY]));
   assign nz = sat_coord(SUM_W'(z_ff) + SUM_W'(res_ff[OP_EZ]));

   // Point state: replace on load accept, advance when a step finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= X_RST;
         y_ff <= '0;
         z_ff <= '0;
      end else if (req_valid && req_ready && req_action) begin
         x_ff <= req_start_x;
         y_ff <= req_start_y;
         z_ff <= req_start_z;
      end else if (ctrl.fin_fire && !ctrl.fin_load) begin
         x_ff <= nx[COORD_W-1:0];
         y_ff <= ny[COORD_W-1:0];
         z_ff <= nz[COORD_W-1:0];
      end
   end

   // Output register: load on finish, drop on a taken beat
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fin_fire) begin
         if (ctrl.fin_load) begin
            rsp_x_ff   <= x_ff;
            rsp_y_ff   <= y_ff;
            rsp_z_ff   <= z_ff;
            rsp_sat_ff <= 1'b0;
         end else begin
            rsp_x_ff   <= nx[COORD_W-1:0];
            rsp_y_ff   <= ny[COORD_W-1:0];
            rsp_z_ff   <= nz[COORD_W-1:0];
            rsp_sat_ff <= nx[COORD_W] | ny[COORD_W] | nz[COORD_W];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- rtl/lez_mul.sv -----
// Shared signed chunk multiplier with registered product.
module lez_mul
   import lez_pkg::*;
(
   input  logic                     clock,
   input  logic signed [PART_W-1:0] mul_a,
   input  logic signed [OPB_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;

   // Full-width signed product of one chunk
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/lez_seq.sv -----
// Sequencer that walks the seven products of one Euler step, or goes straight to finish for a load.
module lez_seq
   import lez_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_action,
   input  logic     out_free,
   output logic     req_ready,
   output ctrl_type ctrl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [PH_W-1:0] ph_ff, ph_in;
   logic            load_ff, load_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ph_in    = ph_ff;
      load_in  = load_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               load_in  = req_action;
               op_in    = OP_SG_DX;
               ph_in    = PH_LO;
               state_in = req_action ? ST_FIN : ST_RUN;
            end
         end
         ST_RUN: begin
            if (ph_ff == PH_ACC) begin
               ph_in = PH_LO;
               if (op_ff == OP_LAST) begin
                  state_in = ST_FIN;
               end else begin
                  op_in = op_ff + 1'b1;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SG_DX;
         ph_ff    <= PH_LO;
         load_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ph_ff    <= ph_in;
         load_ff  <= load_in;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign ctrl.op       = op_ff;
   assign ctrl.phase    = ph_ff;
   assign ctrl.run      = (state_ff == ST_RUN);
   assign ctrl.fin_fire = (state_ff == ST_FIN) && out_free;
   assign ctrl.fin_load = load_ff;

endmodule

// ----- rtl/lez_check.sv -----
// Port-level checker for the Lorenz Euler integrator, bound to the top level.
module lez_check
   import lez_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_action,
   input logic signed [COORD_W-1:0] req_start_x,
   input logic signed [COORD_W-1:0] req_start_y,
   input logic signed [COORD_W-1:0] req_start_z,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_out_x,
   input logic signed [COORD_W-1:0] rsp_out_y,
   input logic signed [COORD_W-1:0] rsp_out_z,
   input logic                      rsp_saturated
);

   // A result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                  && $stable(rsp_out_z) && $stable(rsp_saturated))
      else $error("result beat changed before it was taken");

   // Reset empties the output register
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A step keeps the input side busy while the products run
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_action |=> !req_ready)
      else $error("input ready during an Euler step");

   // A load with a free output returns the start point unclipped, via the finish state and output register
   a_load_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action && (!rsp_valid || rsp_ready)
      |=> ##1 rsp_valid && !rsp_saturated && (rsp_out_x == $past(req_start_x, 2))
              && (rsp_out_y == $past(req_start_y, 2)) && (rsp_out_z == $past(req_start_z, 2)))
      else $error("load result does not match start point");

endmodule

bind lorenz_euler_step lez_check u_check (.*);

// ----- bench/lorenz_euler_step_chk.sv -----
// Codes shared by the bench files, and the checker that predicts and compares result beats.
package lez_tb_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SIGMA = 2'd0,
      CSR_RHO   = 2'd1,
      CSR_BETA  = 2'd2,
      CSR_DT    = 2'd3
   } csr_reg_type;

   // Request actions
   typedef enum logic {
      ACT_STEP = 1'b0,
      ACT_LOAD = 1'b1
   } item_action_type;

   // Values after reset
   localparam logic [30:0] SIGMA_RESET = 31'd167772160;
   localparam logic [30:0] RHO_RESET   = 31'd335544320;
   localparam logic [30:0] BETA_RESET  = 31'd44739243;
   localparam logic [23:0] DT_RESET    = 24'd167772;
   localparam logic [31:0] ONE_Q       = 32'h0100_0000;

endpackage

module lorenz_euler_step_chk
   import lez_pkg::*;
   import lez_tb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [COEF_W-1:0]         csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_action,
   input  logic [COORD_W-1:0]        req_start_x,
   input  logic [COORD_W-1:0]        req_start_y,
   input  logic [COORD_W-1:0]        req_start_z,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [COORD_W-1:0]        rsp_out_x,
   input  logic [COORD_W-1:0]        rsp_out_y,
   input  logic [COORD_W-1:0]        rsp_out_z,
   input  logic                      rsp_saturated,
   output int                        mismatches,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDE_W  = 128;
   localparam int MAX_LOG = 40;
   localparam logic signed [WIDE_W-1:0] COORD_MAX = 128'sh7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] COORD_MIN = -128'sh8000_0000;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               sat;
   } point_beat_type;

   // Mirror of the block's point and coefficients
   logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
   logic [COEF_W-1:0]         sigma_q, rho_q, beta_q;
   logic [DT_W-1:0]           dt_q;

   point_beat_type expected_points [$];
   int             rsp_count = 0;

   // Fixed-point product, rounded toward minus infinity
   function automatic logic signed [WIDE_W-1:0] qmul(input logic signed [WIDE_W-1:0] a,
                                                     input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W-1:0] p;
      p = a * b;
      return p >>> FRAC_W;
   endfunction

   // Clip to 32 bits; bit 32 flags a clip
   function automatic logic [COORD_W:0] clip_coord(input logic signed [WIDE_W-1:0] v);
      if (v > COORD_MAX) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < COORD_MIN) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b0, v[COORD_W-1:0]};
      end
   endfunction

   // Point after one request beat, from the current mirror
   function automatic point_beat_type euler_update(input logic act,
                                                   input logic [COORD_W-1:0] sx,
                                                   input logic [COORD_W-1:0] sy,
                                                   input logic [COORD_W-1:0] sz);
      point_beat_type           r;
      logic signed [WIDE_W-1:0] x, y, z, sg, rh, bt, dt, ex, ey, ez;
      logic [COORD_W:0]         cx, cy, cz;
      if (act == ACT_LOAD) begin
         r.x   = sx;
         r.y   = sy;
         r.z   = sz;
         r.sat = 1'b0;
      end else begin
         x  = coord_x;
         y  = coord_y;
         z  = coord_z;
         sg = sigma_q;
         rh = rho_q;
         bt = beta_q;
         dt = dt_q;
         // all three updates use the old point
         ex = qmul(qmul(sg, y - x), dt);
         ey = qmul(qmul(x, rh - z) - y, dt);
         ez = qmul(qmul(x, y) - qmul(bt, z), dt);
         cx = clip_coord(x + ex);
         cy = clip_coord(y + ey);
         cz = clip_coord(z + ez);
         r.x   = cx[COORD_W-1:0];
         r.y   = cy[COORD_W-1:0];
         r.z   = cz[COORD_W-1:0];
         r.sat = cx[COORD_W] | cy[COORD_W] | cz[COORD_W];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_LOG) begin
         $display("ERROR %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   // Track config, predict on request beats, compare on result beats
   always @(posedge clock) begin : track
      point_beat_type nxt;
      point_beat_type due;
      if (reset) begin
         coord_x = ONE_Q;
         coord_y = '0;
         coord_z = '0;
         sigma_q = SIGMA_RESET;
         rho_q   = RHO_RESET;
         beta_q  = BETA_RESET;
         dt_q    = DT_RESET;
         expected_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SIGMA: sigma_q = csr_wdata;
               CSR_RHO:   rho_q   = csr_wdata;
               CSR_BETA:  beta_q  = csr_wdata;
               CSR_DT:    dt_q    = csr_wdata[DT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            nxt = euler_update(req_action, req_start_x, req_start_y, req_start_z);
            coord_x = nxt.x;
            coord_y = nxt.y;
            coord_z = nxt.z;
            expected_points.push_back(nxt);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing pending", rsp_count));
            end else begin
               due = expected_points.pop_front();
               if (rsp_out_x !== due.x)
                  report_mismatch($sformatf("beat %0d out_x got %h expected %h",
                                            rsp_count, rsp_out_x, due.x));
               if (rsp_out_y !== due.y)
                  report_mismatch($sformatf("beat %0d out_y got %h expected %h",
                                            rsp_count, rsp_out_y, due.y));
               if (rsp_out_z !== due.z)
                  report_mismatch($sformatf("beat %0d out_z got %h expected %h",
                                            rsp_count, rsp_out_z, due.z));
               if (rsp_saturated !== due.sat)
                  report_mismatch($sformatf("beat %0d saturated got %b expected %b",
                                            rsp_count, rsp_saturated, due.sat));
            end
            rsp_count++;
         end
      end
      pending = expected_points.size();
   end

endmodule

// ----- bench/lorenz_euler_step_tb.sv -----
// Top of the bench: clock, reset, stimulus, result sink, watchdog and verdict.
module lorenz_euler_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lez_pkg::*;
   import lez_tb_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 400;
   localparam int HOLD_AT    = 700;
   localparam int TAIL_WAIT  = 30;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [1:0]                csr_index;
   logic [COEF_W-1:0]         csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_action;
   logic signed [COORD_W-1:0] req_start_x, req_start_y, req_start_z;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [COORD_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic                      rsp_saturated;

   int mismatches;
   int pending;
   int rsp_beats   = 0;
   int idle_cycles = 0;
   int calm_items  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lorenz_euler_step u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_start_z   (req_start_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   lorenz_euler_step_chk u_chk (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_start_z   (req_start_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   // Either a point near the attractor or any 32-bit pattern
   function automatic logic [COORD_W-1:0] rand_coord(input int wide_pct);
      if ($urandom_range(0, 99) < wide_pct) return $urandom();
      return $urandom_range(0, 32'd1342177280) - 32'd671088640;
   endfunction

   // Offer one request beat and hold it until accepted; starts and ends at a falling edge
   task automatic send_beat(input logic act, input logic [COORD_W-1:0] sx,
                            input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] sz);
      int gap;
      if (calm_items > 0) begin
         gap = 0;
         calm_items--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) < 2) calm_items = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_start_x <= sx;
      req_start_y <= sy;
      req_start_z <= sz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic step_beat();
      send_beat(ACT_STEP, $urandom(), $urandom(), $urandom());
   endtask

   // Stop offering and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Write all four registers while the block is idle
   task automatic reconfigure(input logic [COEF_W-1:0] sg, input logic [COEF_W-1:0] rh,
                              input logic [COEF_W-1:0] bt, input logic [COEF_W-1:0] dtw);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_SIGMA;
      csr_wdata <= sg;
      @(negedge clock);
      csr_index <= CSR_RHO;
      csr_wdata <= rh;
      @(negedge clock);
      csr_index <= CSR_BETA;
      csr_wdata <= bt;
      @(negedge clock);
      csr_index <= CSR_DT;
      csr_wdata <= dtw;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_items(input int count, input int load_pct, input int wide_pct);
      logic act;
      for (int i = 0; i < count; i++) begin
         act = ($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_STEP;
         send_beat(act, rand_coord(wide_pct), rand_coord(wide_pct), rand_coord(wide_pct));
      end
   endtask

   // Count result beats to time the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) rsp_beats <= rsp_beats + 1;
   end

   // Result sink: random stalls, calm stretches, one long hold-off
   initial begin : result_sink
      int  stall_left;
      int  calm_left;
      bit  held;
      stall_left = 0;
      calm_left  = 0;
      held       = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_beats >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if ($urandom_range(0, 99) < 3) begin
               calm_left = $urandom_range(40, 120);
            end else begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("lorenz_euler_step test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_SIGMA;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_action  = ACT_STEP;
      req_start_x = '0;
      req_start_y = '0;
      req_start_z = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: steps from the reset point, loads of extreme points
      repeat (3) step_beat();
      send_beat(ACT_LOAD, '0, '0, '0);
      step_beat();
      send_beat(ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      step_beat();
      send_beat(ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      step_beat();
      send_beat(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, '0);
      step_beat();
      send_beat(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      step_beat();

      // Directed: largest coefficients, dt written with bits above its width
      reconfigure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_beat(ACT_LOAD, ONE_Q, ONE_Q, ONE_Q);
      step_beat();
      step_beat();
      send_beat(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      step_beat();

      // Directed: zero coefficients freeze the point
      reconfigure('0, '0, '0, '0);
      step_beat();
      step_beat();

      // Random: reset values written back
      reconfigure(SIGMA_RESET, RHO_RESET, BETA_RESET, {7'd0, DT_RESET});
      random_items(500, 3, 20);

      // Random: classic chaotic setting, random dt; long result hold-off lands here
      reconfigure(31'd167772160, 31'd469762048, BETA_RESET,
                  COEF_W'($urandom_range(16777, 335544)));
      random_items(500, 3, 15);

      // Random: any register pattern
      reconfigure(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                  COEF_W'($urandom()));
      random_items(300, 10, 50);

      // Random: largest coefficients, saturation most of the time
      reconfigure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h00FF_FFFF);
      random_items(150, 20, 40);

      // Random: zero coefficients
      reconfigure('0, '0, '0, '0);
      random_items(100, 20, 50);

      // Random: moderate coefficients
      reconfigure(COEF_W'($urandom_range(0, 503316480)), COEF_W'($urandom_range(0, 838860800)),
                  COEF_W'($urandom_range(0, 167772160)), COEF_W'($urandom_range(0, 838860)));
      random_items(450, 5, 20);

      // Wait for the last results, then a little longer
      drain_results();
      repeat (TAIL_WAIT) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("lorenz_euler_step test passed");
      end else begin
         $display("lorenz_euler_step test failed");
      end
      $finish;
   end

endmodule
